// File: src/grid_ray_cast_horizontal_assert.svh
// assertion macros for the horizontal ray cast block
`ifndef GRID_RAY_CAST_HORIZONTAL_ASSERT_SVH
`define GRID_RAY_CAST_HORIZONTAL_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet while rst_n is low
`define GRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/grcast_pkg.sv
// ----------------------------------------------------------------------------
// grcast_pkg
// shared constants, types and helper functions of the horizontal ray cast
// ----------------------------------------------------------------------------
package grcast_pkg;

  localparam int MAP_SIDE   = 8;
  localparam int MAX_STEPS  = 8;
  localparam int CELL_SHIFT = 6;
  localparam int FRAC_BITS  = 6;
  localparam int TILE_SHIFT = CELL_SHIFT + FRAC_BITS;
  localparam int MAP_CELLS  = MAP_SIDE * MAP_SIDE;
  localparam int CELL_IDX_W = $clog2(MAP_CELLS);
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);

  localparam int POS_W   = 15;
  localparam int ANG_W   = 16;
  localparam int COORD_W = 18;
  localparam int COORD_XW = COORD_W + 1;
  localparam int TILE_W  = COORD_W + 2 - TILE_SHIFT;
  localparam int IDX_W   = TILE_W + 5;
  localparam int MAP_W   = 64;

  localparam int PI_Q13      = 25736;
  localparam int TWO_PI_Q13  = 51472;
  localparam int HALF_PI_Q13 = 12868;

  // cordic datapath
  localparam int CORDIC_ITERS = 16;
  localparam int CW = 18;
  localparam int ZW = 20;
  localparam int CORDIC_X0 = 16384;

  // cotangent divider
  localparam int COT_FRAC = 12;
  localparam int COT_QB   = 20;
  localparam int COT_W    = COT_QB + 1;
  localparam int AW       = CW;
  localparam int RW       = AW + 1;
  localparam int NUM_W    = AW + COT_FRAC;

  // walk datapath
  localparam int PW    = COORD_W + COT_W;
  localparam int SAT_W = 48;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** (COORD_W - 1) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(2 ** (COORD_W - 1));
  localparam logic signed [COORD_W-1:0] CELL_UNITS = COORD_W'(2 ** TILE_SHIFT);

  localparam int CFG_AW = 4;
  localparam logic REG_WALL_MAP = 1'b0;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             up;
    logic             is_pi;
  } side_t;

  function automatic int atan_q16(input int i);
    unique case (i)
      0:  atan_q16 = 51472;
      1:  atan_q16 = 30386;
      2:  atan_q16 = 16055;
      3:  atan_q16 = 8150;
      4:  atan_q16 = 4091;
      5:  atan_q16 = 2047;
      6:  atan_q16 = 1024;
      7:  atan_q16 = 512;
      8:  atan_q16 = 256;
      9:  atan_q16 = 128;
      10: atan_q16 = 64;
      11: atan_q16 = 32;
      12: atan_q16 = 16;
      13: atan_q16 = 8;
      14: atan_q16 = 4;
      15: atan_q16 = 2;
      default: atan_q16 = 0;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) begin
      sat_coord = COORD_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      sat_coord = COORD_W'(SAT_LO);
    end else begin
      sat_coord = COORD_W'(v);
    end
  endfunction

  // truncating toward zero
  function automatic logic signed [TILE_W-1:0] tile_of(input logic signed [COORD_W-1:0] v);
    logic [COORD_XW-1:0] mag;
    logic [COORD_XW-1:0] sh;
    mag = v[COORD_W-1] ? COORD_XW'(-{v[COORD_W-1], v}) : {1'b0, v};
    sh  = mag >> TILE_SHIFT;
    tile_of = v[COORD_W-1] ? -TILE_W'(sh) : TILE_W'(sh);
  endfunction

endpackage

// File: src/grcast_cordic.sv
// ----------------------------------------------------------------------------
// grcast_cordic
// angle fold and pipelined rotation, one cordic iteration per stage
// ----------------------------------------------------------------------------
module grcast_cordic import grcast_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  side_t                in_side,
  input  logic [ANG_W-1:0]     in_angle,
  output logic                 out_valid,
  output side_t                out_side,
  output logic signed [CW-1:0] out_cos,
  output logic signed [CW-1:0] out_sin
);

  logic                 v_r    [0:CORDIC_ITERS];
  side_t                side_r [0:CORDIC_ITERS];
  logic                 neg_r  [0:CORDIC_ITERS];
  logic signed [CW-1:0] x_r    [0:CORDIC_ITERS];
  logic signed [CW-1:0] y_r    [0:CORDIC_ITERS];
  logic signed [ZW-1:0] z_r    [0:CORDIC_ITERS];

  logic                 vo_r;
  side_t                so_r;
  logic signed [CW-1:0] co_r;
  logic signed [CW-1:0] sn_r;

  logic signed [CW-1:0] a_red;
  logic signed [CW-1:0] a_fold;
  logic                 a_neg;

  // reduce to (-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    a_red = $signed({2'b00, in_angle});
    if (in_angle > ANG_W'(PI_Q13)) begin
      a_red = a_red - CW'(TWO_PI_Q13);
    end
    a_fold = a_red;
    a_neg  = 1'b0;
    if (a_red > CW'(HALF_PI_Q13)) begin
      a_fold = a_red - CW'(PI_Q13);
      a_neg  = 1'b1;
    end else if (a_red < -CW'(HALF_PI_Q13)) begin
      a_fold = a_red + CW'(PI_Q13);
      a_neg  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      neg_r[0]  <= a_neg;
      x_r[0]    <= CW'(CORDIC_X0);
      y_r[0]    <= '0;
      z_r[0]    <= ZW'(a_fold) <<< 3;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q16(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[i+1] <= side_r[i];
        neg_r[i+1]  <= neg_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv) begin
      vo_r <= v_r[CORDIC_ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      so_r <= side_r[CORDIC_ITERS];
      co_r <= neg_r[CORDIC_ITERS] ? -x_r[CORDIC_ITERS] : x_r[CORDIC_ITERS];
      sn_r <= neg_r[CORDIC_ITERS] ? -y_r[CORDIC_ITERS] : y_r[CORDIC_ITERS];
    end
  end

  assign out_valid = vo_r;
  assign out_side  = so_r;
  assign out_cos   = co_r;
  assign out_sin   = sn_r;

endmodule

// File: src/grcast_div.sv
// ----------------------------------------------------------------------------
// grcast_div
// pipelined restoring divide giving the saturated Q.12 cotangent
// ----------------------------------------------------------------------------
module grcast_div import grcast_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  side_t                   in_side,
  input  logic signed [CW-1:0]    in_cos,
  input  logic signed [CW-1:0]    in_sin,
  output logic                    out_valid,
  output side_t                   out_side,
  output logic signed [COT_W-1:0] out_cot
);

  logic              v_r    [0:COT_QB];
  side_t             side_r [0:COT_QB];
  logic              ovf_r  [0:COT_QB];
  logic              sgn_r  [0:COT_QB];
  logic [AW-1:0]     den_r  [0:COT_QB];
  logic [RW-1:0]     rem_r  [0:COT_QB];
  logic [COT_QB-1:0] lo_r   [0:COT_QB];
  logic [COT_QB-1:0] q_r    [0:COT_QB];

  logic                    vo_r;
  side_t                   so_r;
  logic signed [COT_W-1:0] cot_r;

  logic [AW-1:0]    ax;
  logic [AW-1:0]    ay;
  logic [NUM_W-1:0] num;
  logic [RW-1:0]    num_hi;

  always_comb begin
    ax     = in_cos[CW-1] ? AW'(-in_cos) : AW'(in_cos);
    ay     = in_sin[CW-1] ? AW'(-in_sin) : AW'(in_sin);
    num    = {ax, {COT_FRAC{1'b0}}};
    num_hi = RW'(num[NUM_W-1:COT_QB]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  // a zero sine always overflows here and so takes the sign of the cosine
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      ovf_r[0]  <= num_hi >= RW'(ay);
      sgn_r[0]  <= in_cos[CW-1] ^ in_sin[CW-1];
      den_r[0]  <= ay;
      rem_r[0]  <= num_hi;
      lo_r[0]   <= num[COT_QB-1:0];
      q_r[0]    <= '0;
    end
  end

  for (genvar j = 0; j < COT_QB; j++) begin : g_bit
    logic [RW-1:0] r2;
    assign r2 = {rem_r[j][RW-2:0], lo_r[j][COT_QB-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (adv) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[j+1] <= side_r[j];
        ovf_r[j+1]  <= ovf_r[j];
        sgn_r[j+1]  <= sgn_r[j];
        den_r[j+1]  <= den_r[j];
        lo_r[j+1]   <= lo_r[j] << 1;
        if (r2 >= RW'(den_r[j])) begin
          rem_r[j+1] <= r2 - RW'(den_r[j]);
          q_r[j+1]   <= {q_r[j][COT_QB-2:0], 1'b1};
        end else begin
          rem_r[j+1] <= r2;
          q_r[j+1]   <= {q_r[j][COT_QB-2:0], 1'b0};
        end
      end
    end
  end

  logic [COT_QB-1:0]       q_sat;
  logic signed [COT_W-1:0] q_pos;

  assign q_sat = ovf_r[COT_QB] ? {COT_QB{1'b1}} : q_r[COT_QB];
  assign q_pos = $signed({1'b0, q_sat});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv) begin
      vo_r <= v_r[COT_QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      so_r  <= side_r[COT_QB];
      cot_r <= sgn_r[COT_QB] ? -q_pos : q_pos;
    end
  end

  assign out_valid = vo_r;
  assign out_side  = so_r;
  assign out_cot   = cot_r;

endmodule

// File: src/grcast_walk.sv
// ----------------------------------------------------------------------------
// grcast_walk
// first grid line crossing, then one map test and advance per stage
// ----------------------------------------------------------------------------
module grcast_walk import grcast_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [MAP_W-1:0]          wall_map,
  input  logic                      in_valid,
  input  side_t                     in_side,
  input  logic signed [COT_W-1:0]   in_cot,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_hit_x,
  output logic signed [COORD_W-1:0] out_hit_y,
  output logic                      out_wall_hit,
  output logic [STEP_W-1:0]         out_steps
);

  `include "grid_ray_cast_horizontal_assert.svh"

  localparam logic signed [IDX_W-1:0] SIDE_S = IDX_W'(MAP_SIDE);
  localparam logic signed [IDX_W-1:0] CELLS_S = IDX_W'(MAP_CELLS);
  localparam logic [PW:0] ROUND_HALF = (PW+1)'(2 ** (COT_FRAC - 1));

  // first stage: grid line and product
  logic                      v1_r;
  side_t                     s1_r;
  logic signed [PW-1:0]      p1_r;
  logic signed [COT_W-1:0]   sx1_r;
  logic signed [COORD_W-1:0] ry1_r;

  logic [POS_W-1:0]          py_floor;
  logic signed [COORD_W-1:0] ry0;
  logic signed [COORD_W-1:0] dy;

  always_comb begin
    py_floor = in_side.pos_y & ~POS_W'(2 ** TILE_SHIFT - 1);
    ry0 = $signed(COORD_W'(py_floor)) + (in_side.up ? COORD_W'(0) : CELL_UNITS);
    dy  = ry0 - $signed(COORD_W'(in_side.pos_y));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  // a full cell times the cotangent is exact, so the step is the cotangent itself
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= in_side;
      p1_r  <= PW'(dy) * PW'(in_cot);
      sx1_r <= in_side.up ? -in_cot : in_cot;
      ry1_r <= ry0;
    end
  end

  // walk stages
  logic                      v_r    [0:MAX_STEPS];
  side_t                     side_r [0:MAX_STEPS];
  logic signed [COORD_W-1:0] rx_r   [0:MAX_STEPS];
  logic signed [COORD_W-1:0] ry_r   [0:MAX_STEPS];
  logic signed [COT_W-1:0]   sx_r   [0:MAX_STEPS];
  logic                      done_r [0:MAX_STEPS];
  logic                      hit_r  [0:MAX_STEPS];
  logic [STEP_W-1:0]         steps_r[0:MAX_STEPS];

  logic [PW:0]            mag;
  logic [PW:0]            rnd;
  logic signed [PW+1:0]   off;

  // round half away from zero
  always_comb begin
    mag = p1_r[PW-1] ? (PW+1)'(-{p1_r[PW-1], p1_r}) : {1'b0, p1_r};
    rnd = (mag + ROUND_HALF) >> COT_FRAC;
    off = p1_r[PW-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0]  <= s1_r;
      sx_r[0]    <= sx1_r;
      hit_r[0]   <= 1'b0;
      steps_r[0] <= '0;
      done_r[0]  <= s1_r.is_pi;
      if (s1_r.is_pi) begin
        rx_r[0] <= $signed(COORD_W'(s1_r.pos_x));
        ry_r[0] <= $signed(COORD_W'(s1_r.pos_y));
      end else begin
        rx_r[0] <= sat_coord(SAT_W'($signed({1'b0, s1_r.pos_x})) + SAT_W'(off));
        ry_r[0] <= sat_coord(SAT_W'(ry1_r));
      end
    end
  end

  for (genvar k = 0; k < MAX_STEPS; k++) begin : g_step
    logic signed [TILE_W-1:0] tx;
    logic signed [TILE_W-1:0] ty;
    logic signed [IDX_W-1:0]  idx;
    logic                     wall;
    logic signed [COORD_W-1:0] sy;

    always_comb begin
      tx   = tile_of(rx_r[k]);
      ty   = tile_of(ry_r[k]) - (side_r[k].up ? TILE_W'(1) : TILE_W'(0));
      idx  = IDX_W'(ty) * SIDE_S + IDX_W'(tx);
      // negative columns may alias into the previous row
      wall = (idx >= 0) && (idx < CELLS_S) && wall_map[idx[CELL_IDX_W-1:0]];
      sy   = side_r[k].up ? -CELL_UNITS : CELL_UNITS;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[k+1] <= side_r[k];
        sx_r[k+1]   <= sx_r[k];
        priority if (done_r[k]) begin
          rx_r[k+1]    <= rx_r[k];
          ry_r[k+1]    <= ry_r[k];
          done_r[k+1]  <= 1'b1;
          hit_r[k+1]   <= hit_r[k];
          steps_r[k+1] <= steps_r[k];
        end else if (wall) begin
          rx_r[k+1]    <= rx_r[k];
          ry_r[k+1]    <= ry_r[k];
          done_r[k+1]  <= 1'b1;
          hit_r[k+1]   <= 1'b1;
          steps_r[k+1] <= steps_r[k];
        end else begin
          rx_r[k+1]    <= sat_coord(SAT_W'(rx_r[k]) + SAT_W'(sx_r[k]));
          ry_r[k+1]    <= sat_coord(SAT_W'(ry_r[k]) + SAT_W'(sy));
          done_r[k+1]  <= 1'b0;
          hit_r[k+1]   <= 1'b0;
          steps_r[k+1] <= steps_r[k] + STEP_W'(1);
        end
      end
    end
  end

  assign out_valid    = v_r[MAX_STEPS];
  assign out_hit_x    = rx_r[MAX_STEPS];
  assign out_hit_y    = ry_r[MAX_STEPS];
  assign out_wall_hit = hit_r[MAX_STEPS];
  assign out_steps    = steps_r[MAX_STEPS];

  `GRC_ASSERT_NOW(a_miss_full_walk,
    v_r[MAX_STEPS] && !hit_r[MAX_STEPS] && !side_r[MAX_STEPS].is_pi,
    steps_r[MAX_STEPS] == STEP_W'(MAX_STEPS),
    "ray without wall hit did not take every step")
  `GRC_ASSERT_NOW(a_pi_no_walk,
    v_r[MAX_STEPS] && side_r[MAX_STEPS].is_pi,
    !hit_r[MAX_STEPS] && steps_r[MAX_STEPS] == '0,
    "ray at pi walked or hit")
  `GRC_ASSERT_NEXT(a_stall_holds,
    !adv && v_r[MAX_STEPS],
    v_r[MAX_STEPS] && $stable(rx_r[MAX_STEPS]) && $stable(steps_r[MAX_STEPS]),
    "stalled result changed")

endmodule

// File: src/grid_ray_cast_horizontal.sv
// pipeline: angle rotation, then cotangent divide, then grid walk, from input word to result word
// throughput: one ray per cycle while results are taken; the whole pipeline
// freezes as one when the output word is held
// reset: synchronous active-low rst_n clears all stage valid bits and the wall map
// ----------------------------------------------------------------------------
// grid_ray_cast_horizontal
// horizontal grid line ray cast over an 8x8 wall bitmap with apb config
// ----------------------------------------------------------------------------
module grid_ray_cast_horizontal import grcast_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // pos_x[14:0], pos_y[29:15], ray_angle[45:30], zero
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // hit_x[17:0], hit_y[35:18], wall_hit[36],
                                        // steps_taken[40:37], zero
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [MAP_W-1:0]  cfg_pwdata,
  output logic [MAP_W-1:0]  cfg_prdata,
  output logic              cfg_pready
);

  logic [MAP_W-1:0] wall_map_r;
  logic             adv;
  side_t            in_side;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[3] == REG_WALL_MAP) ? wall_map_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_map_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[3] == REG_WALL_MAP) begin
      wall_map_r <= cfg_pwdata;
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_comb begin
    in_side.pos_x = in_tdata[14:0];
    in_side.pos_y = in_tdata[29:15];
    in_side.up    = in_tdata[45:30] > ANG_W'(PI_Q13);
    in_side.is_pi = in_tdata[45:30] == ANG_W'(PI_Q13);
  end

  logic                 c_valid;
  side_t                c_side;
  logic signed [CW-1:0] c_cos;
  logic signed [CW-1:0] c_sin;

  grcast_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_side   (in_side),
    .in_angle  (in_tdata[45:30]),
    .out_valid (c_valid),
    .out_side  (c_side),
    .out_cos   (c_cos),
    .out_sin   (c_sin)
  );

  logic                    d_valid;
  side_t                   d_side;
  logic signed [COT_W-1:0] d_cot;

  grcast_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (c_valid),
    .in_side   (c_side),
    .in_cos    (c_cos),
    .in_sin    (c_sin),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_cot   (d_cot)
  );

  logic signed [COORD_W-1:0] hit_x;
  logic signed [COORD_W-1:0] hit_y;
  logic                      wall_hit;
  logic [STEP_W-1:0]         steps;

  grcast_walk u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .wall_map     (wall_map_r),
    .in_valid     (d_valid),
    .in_side      (d_side),
    .in_cot       (d_cot),
    .out_valid    (out_tvalid),
    .out_hit_x    (hit_x),
    .out_hit_y    (hit_y),
    .out_wall_hit (wall_hit),
    .out_steps    (steps)
  );

  assign out_tdata = {7'b0, 4'(steps), wall_hit, hit_y, hit_x};

endmodule
